FILE: rtl/hwrr_pkg.sv
`timescale 1ns / 1ps

package hwrr_pkg;

  // Millisecond counters and limit registers
  localparam int unsigned CntW = 25;
  localparam int unsigned RegW = 24;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [RegW-1:0] reg_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT       = 2'd0,
    CFG_SEND_INTERVAL = 2'd1,
    CFG_SEND_PULSE    = 2'd2,
    CFG_RELAY_PULSE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_GRACE   = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  localparam reg_t TimeoutRst       = 24'd5000;
  localparam reg_t SendIntervalRst  = 24'd1000;
  localparam reg_t SendPulseRst     = 24'd50;
  localparam reg_t RelayPulseRst    = 24'd500;

  // Saturating increment: sticks at all ones
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (&v) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

endpackage

FILE: rtl/heartbeat_watchdog_relay_reset.sv
`timescale 1ns / 1ps

// Heartbeat watchdog with partner reset relay. Each input beat is one update
// (tick = one millisecond elapsed, rx_edge = heartbeat edge received,
// sensor_ok = local sensor healthy); each update produces exactly one output
// beat with the heartbeat pin level, the relay level, the status (ok, grace
// before the first edge, timeout) and the sticky timeout flag. In an update,
// the millisecond counters, the edge handling and the step rule are one
// combinational pass from the state registers into the state and the output
// register, so a new beat is accepted every cycle as long as the output
// register is free or being drained in the same cycle. All counters are 25
// bits and saturate, so a timeout persists until a heartbeat edge arrives.
// Registers (24-bit, milliseconds) are written over the cfg channel, which is
// always ready; index 0 timeout/cooldown, 1 send interval, 2 send pulse
// length, 3 relay pulse length. Write them only while the block is idle.
module heartbeat_watchdog_relay_reset (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hwrr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hwrr_pkg::RegW-1:0]   cfg_data_i,
  // update channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        tick_i,
  input  logic                        rx_edge_i,
  input  logic                        sensor_ok_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hb_out_o,
  output logic                        relay_on_o,
  output logic [1:0]                  status_o,
  output logic                        timeout_latched_o
);
  import hwrr_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  reg_t timeout_q, send_interval_q, send_pulse_q, relay_pulse_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q       <= TimeoutRst;
      send_interval_q <= SendIntervalRst;
      send_pulse_q    <= SendPulseRst;
      relay_pulse_q   <= RelayPulseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:       timeout_q       <= cfg_data_i;
        CFG_SEND_INTERVAL: send_interval_q <= cfg_data_i;
        CFG_SEND_PULSE:    send_pulse_q    <= cfg_data_i;
        CFG_RELAY_PULSE:   relay_pulse_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero-extended limits for compare against the 25-bit counters
  cnt_t timeout_x, send_interval_x, send_pulse_x, relay_pulse_x;
  assign timeout_x       = {1'b0, timeout_q};
  assign send_interval_x = {1'b0, send_interval_q};
  assign send_pulse_x    = {1'b0, send_pulse_q};
  assign relay_pulse_x   = {1'b0, relay_pulse_q};

  // ---------------------------------------------------------------------
  // Handshake: output register drains or is empty -> take a new beat
  // ---------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  logic in_fire, out_fire;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  // ---------------------------------------------------------------------
  // Watchdog state
  // ---------------------------------------------------------------------
  cnt_t idle_q, idle_d;
  cnt_t since_trig_q, since_trig_d;
  cnt_t since_send_q, since_send_d;
  cnt_t pulse_cnt_q, pulse_cnt_d;
  cnt_t relay_cnt_q, relay_cnt_d;
  logic seen_q, seen_d;
  logic latch_q, latch_d;
  logic pulse_act_q, pulse_act_d;
  logic relay_act_q, relay_act_d;

  logic    timed_out;
  status_e status_d;

  always_comb begin
    idle_d       = idle_q;
    since_trig_d = since_trig_q;
    since_send_d = since_send_q;
    pulse_cnt_d  = pulse_cnt_q;
    relay_cnt_d  = relay_cnt_q;
    seen_d       = seen_q;
    latch_d      = latch_q;
    pulse_act_d  = pulse_act_q;
    relay_act_d  = relay_act_q;

    // millisecond advance
    if (tick_i) begin
      idle_d       = sat_inc(idle_q);
      since_trig_d = sat_inc(since_trig_q);
      since_send_d = sat_inc(since_send_q);
      pulse_cnt_d  = sat_inc(pulse_cnt_q);
      relay_cnt_d  = sat_inc(relay_cnt_q);
    end

    // received edge wins over a timeout in the same update
    if (rx_edge_i) begin
      seen_d  = 1'b1;
      idle_d  = '0;
      latch_d = 1'b0;
    end

    // outgoing heartbeat pulse start, then end (zero length ends at once)
    if (sensor_ok_i && (since_send_d >= send_interval_x)) begin
      since_send_d = '0;
      pulse_act_d  = 1'b1;
      pulse_cnt_d  = '0;
    end
    if (pulse_act_d && (pulse_cnt_d >= send_pulse_x)) begin
      pulse_act_d = 1'b0;
    end

    timed_out = idle_d > timeout_x;
    if (timed_out) begin
      latch_d = 1'b1;
    end

    // relay fires once cooldown (also timeout_ms) has passed
    if (timed_out && !relay_act_d && (since_trig_d >= timeout_x)) begin
      seen_d       = 1'b0;
      since_trig_d = '0;
      relay_act_d  = 1'b1;
      relay_cnt_d  = '0;
    end
    if (relay_act_d && (relay_cnt_d >= relay_pulse_x)) begin
      relay_act_d = 1'b0;
    end

    if (timed_out) begin
      status_d = STATUS_TIMEOUT;
    end else if (seen_d) begin
      status_d = STATUS_OK;
    end else begin
      status_d = STATUS_GRACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q       <= '0;
      since_trig_q <= '1;
      since_send_q <= '1;
      pulse_cnt_q  <= '0;
      relay_cnt_q  <= '0;
      seen_q       <= 1'b0;
      latch_q      <= 1'b0;
      pulse_act_q  <= 1'b0;
      relay_act_q  <= 1'b0;
    end else if (in_fire) begin
      idle_q       <= idle_d;
      since_trig_q <= since_trig_d;
      since_send_q <= since_send_d;
      pulse_cnt_q  <= pulse_cnt_d;
      relay_cnt_q  <= relay_cnt_d;
      seen_q       <= seen_d;
      latch_q      <= latch_d;
      pulse_act_q  <= pulse_act_d;
      relay_act_q  <= relay_act_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic    hb_out_q, relay_on_q, latched_q;
  status_e status_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hb_out_q   <= pulse_act_d;
      relay_on_q <= relay_act_d;
      status_q   <= status_d;
      latched_q  <= latch_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hb_out_o          = hb_out_q;
  assign relay_on_o        = relay_on_q;
  assign status_o          = status_q;
  assign timeout_latched_o = latched_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a timeout status always comes with the latch set
  a_timeout_latched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == STATUS_TIMEOUT)) |-> latched_q)
    else $error("timeout status without latch");

  // an edge clears the timeout in the result of its own update
  a_edge_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && rx_edge_i) |=> ((status_q != STATUS_TIMEOUT) && !latched_q))
    else $error("edge did not clear timeout");

  // every accepted beat yields a result beat
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  // back-pressure only while a result is held
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled with free output register");

endmodule
